// ----- sv/si3d_pkg.sv -----
package si3d_pkg;

  // field and datapath widths
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MUL_W   = 68;
  localparam int HALF_W  = MUL_W / 2;
  localparam int MULP_W  = 2 * MUL_W;
  localparam int SPLIT_W = 66;
  localparam int DEN_W   = 2 * SPLIT_W;
  localparam int X_W     = 166;
  localparam int MAG_W   = X_W - 1;
  localparam int Q_W     = DIFF_W;
  localparam int RES_W   = COORD_W + 3;
  localparam int IN_W    = 12 * COORD_W;
  localparam int OUT_W   = 3 * COORD_W;

  // queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  // classified item handed from front to back
  typedef struct packed {
    coord_t [2:0] as;
    diff_t  [2:0] da;
    diff_t  [2:0] db;
    diff_t  [2:0] dc;
    logic         sh;
  } work_t;

endpackage

// ----- sv/si3d_mul.sv -----
module si3d_mul import si3d_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [MULP_W-1:0] p_o
);

  logic signed [2*HALF_W+1:0] ll_q;
  logic signed [2*HALF_W:0]   lh_q;
  logic signed [2*HALF_W:0]   hl_q;
  logic signed [2*HALF_W-1:0] hh_q;
  logic signed [MULP_W-1:0]   p_q;

  // partial products on split halves, then recombine
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= $signed({1'b0, a_i[HALF_W-1:0]}) * $signed({1'b0, b_i[HALF_W-1:0]});
      lh_q <= $signed({1'b0, a_i[HALF_W-1:0]}) * $signed(b_i[MUL_W-1:HALF_W]);
      hl_q <= $signed(a_i[MUL_W-1:HALF_W]) * $signed({1'b0, b_i[HALF_W-1:0]});
      hh_q <= $signed(a_i[MUL_W-1:HALF_W]) * $signed(b_i[MUL_W-1:HALF_W]);
      p_q  <= (MULP_W'(hh_q) <<< (2 * HALF_W))
            + ((MULP_W'(lh_q) + MULP_W'(hl_q)) <<< HALF_W)
            + MULP_W'(ll_q);
    end
  end

  assign p_o = p_q;

endmodule

// ----- sv/si3d_div.sv -----
module si3d_div import si3d_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] mag_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   q_o,
  output logic             nz_o
);

  logic [MAG_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   q_q   [Q_W];
  logic [DEN_W-1:0] den_q [Q_W-1];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int B = Q_W - 1 - k;
    logic [MAG_W-1:0] rem_in;
    logic [MAG_W-1:0] sub;
    logic [DEN_W-1:0] dv;
    logic [Q_W-1:0]   qin;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = mag_i;
      assign dv     = den_i;
      assign qin    = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dv     = den_q[k-1];
      assign qin    = q_q[k-1];
    end

    assign sub = MAG_W'(dv) << B;
    assign ge  = rem_in >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_in - sub : rem_in;
        q_q[k]   <= qin | (ge ? (Q_W'(1) << B) : '0);
      end
    end

    if (k < Q_W - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[k] <= dv;
        end
      end
    end
  end

  assign q_o  = q_q[Q_W-1];
  assign nz_o = |rem_q[Q_W-1];

endmodule

// ----- sv/si3d_front.sv -----
module si3d_front import si3d_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [IN_W-1:0] in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output work_t           out_work_o
);

  logic  fv_q, fv_d;
  logic  take;
  work_t work_d, work_q;

  // differences and shared endpoint test
  always_comb begin
    coord_t as, ae, bs, be;
    work_d = '0;
    for (int i = 0; i < 3; i++) begin
      as = in_data_i[i*COORD_W +: COORD_W];
      ae = in_data_i[(3+i)*COORD_W +: COORD_W];
      bs = in_data_i[(6+i)*COORD_W +: COORD_W];
      be = in_data_i[(9+i)*COORD_W +: COORD_W];
      work_d.as[i] = as;
      work_d.da[i] = {ae[COORD_W-1], ae} - {as[COORD_W-1], as};
      work_d.db[i] = {be[COORD_W-1], be} - {bs[COORD_W-1], bs};
      work_d.dc[i] = {bs[COORD_W-1], bs} - {as[COORD_W-1], as};
    end
    work_d.sh = (in_data_i[3*COORD_W-1:0]  == in_data_i[9*COORD_W-1:6*COORD_W])
             || (in_data_i[3*COORD_W-1:0]  == in_data_i[12*COORD_W-1:9*COORD_W])
             || (in_data_i[6*COORD_W-1:3*COORD_W] == in_data_i[9*COORD_W-1:6*COORD_W])
             || (in_data_i[6*COORD_W-1:3*COORD_W] == in_data_i[12*COORD_W-1:9*COORD_W]);
  end

  assign in_ready_o = !fv_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    fv_d = fv_q;
    if (take) begin
      fv_d = 1'b1;
    end else if (out_ready_i) begin
      fv_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      work_q <= work_d;
    end
  end

  assign out_valid_o = fv_q;
  assign out_work_o  = work_q;

endmodule

// ----- sv/si3d_fifo.sv -----
module si3d_fifo import si3d_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output work_t data_o
);

  work_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/si3d_back.sv -----
module si3d_back import si3d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  work_t            in_work_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_hit_o,
  output logic [OUT_W-1:0] out_point_o
);

  localparam int LAT = 9 + Q_W;

  typedef struct packed {
    logic         hit;
    logic [2:0]   neg;
    coord_t [2:0] as;
  } side_t;

  logic en;
  logic [LAT-1:0] vld_q;
  logic out_valid_q;
  logic out_hit_q;
  logic [OUT_W-1:0] out_point_q;

  // stage 1: cross product terms
  logic signed [PROD_W-1:0] wpa_q [3], wpb_q [3], cpa_q [3], cpb_q [3], apa_q [3], apb_q [3];
  coord_t as1_q [3];
  diff_t  da1_q [3], dc1_q [3];
  logic   sh1_q;
  // stage 2: cross products
  logic signed [CROSS_W-1:0] w2_q [3], cb2_q [3], ca2_q [3];
  coord_t as2_q [3], as3_q [3], as4_q [3], as5_q [3], as6_q [3], as7_q [3], as8_q [3];
  diff_t  da2_q [3], da3_q [3], da4_q [3], da5_q [3];
  diff_t  dc2_q [3];
  logic   sh2_q, sh3_q, sh4_q, sh5_q;
  // dot product terms
  logic signed [MULP_W-1:0] pww [3], pdw [3], psw [3], ptw [3];
  logic signed [MULP_W-1:0] den5_q, dcw5_q, sn5_q, tn5_q;
  logic signed [MULP_W-1:0] pxl [3], pxh [3];
  logic hit6_q, hit7_q, hit8_q, hit9_q;
  logic [DEN_W-1:0] den6_q, den7_q, den8_q, den9_q;
  logic signed [X_W-1:0] x8_q [3];
  logic [MAG_W-1:0] mag9_q [3];
  logic [2:0] neg9_q;
  coord_t as9_q [3];
  logic [Q_W-1:0] dq [3];
  logic [2:0] dnz;
  side_t sb_q [Q_W];
  logic [OUT_W-1:0] point_d;

  // the whole back end moves when the output slot frees up
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1 and 2 per axis
  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk_i) begin
      if (en) begin
        wpa_q[i] <= $signed(in_work_i.da[J]) * $signed(in_work_i.db[K]);
        wpb_q[i] <= $signed(in_work_i.da[K]) * $signed(in_work_i.db[J]);
        cpa_q[i] <= $signed(in_work_i.dc[J]) * $signed(in_work_i.db[K]);
        cpb_q[i] <= $signed(in_work_i.dc[K]) * $signed(in_work_i.db[J]);
        apa_q[i] <= $signed(in_work_i.dc[J]) * $signed(in_work_i.da[K]);
        apb_q[i] <= $signed(in_work_i.dc[K]) * $signed(in_work_i.da[J]);
        as1_q[i] <= in_work_i.as[i];
        da1_q[i] <= in_work_i.da[i];
        dc1_q[i] <= in_work_i.dc[i];
        w2_q[i]  <= {wpa_q[i][PROD_W-1], wpa_q[i]} - {wpb_q[i][PROD_W-1], wpb_q[i]};
        cb2_q[i] <= {cpa_q[i][PROD_W-1], cpa_q[i]} - {cpb_q[i][PROD_W-1], cpb_q[i]};
        ca2_q[i] <= {apa_q[i][PROD_W-1], apa_q[i]} - {apb_q[i][PROD_W-1], apb_q[i]};
      end
    end

    // dot product terms
    si3d_mul u_ww (.clk_i(clk_i), .en_i(en), .a_i(MUL_W'(w2_q[i])),
                   .b_i(MUL_W'(w2_q[i])), .p_o(pww[i]));
    si3d_mul u_dw (.clk_i(clk_i), .en_i(en), .a_i(MUL_W'(dc2_q[i])),
                   .b_i(MUL_W'(w2_q[i])), .p_o(pdw[i]));
    si3d_mul u_sw (.clk_i(clk_i), .en_i(en), .a_i(MUL_W'(cb2_q[i])),
                   .b_i(MUL_W'(w2_q[i])), .p_o(psw[i]));
    si3d_mul u_tw (.clk_i(clk_i), .en_i(en), .a_i(MUL_W'(ca2_q[i])),
                   .b_i(MUL_W'(w2_q[i])), .p_o(ptw[i]));

    // da times the s numerator, in two halves
    si3d_mul u_xl (.clk_i(clk_i), .en_i(en), .a_i(MUL_W'(da5_q[i])),
                   .b_i({{(MUL_W-SPLIT_W){1'b0}}, sn5_q[SPLIT_W-1:0]}), .p_o(pxl[i]));
    si3d_mul u_xh (.clk_i(clk_i), .en_i(en), .a_i(MUL_W'(da5_q[i])),
                   .b_i({{(MUL_W-SPLIT_W){1'b0}}, sn5_q[DEN_W-1:SPLIT_W]}), .p_o(pxh[i]));

    // truncating division of the offset along a
    si3d_div u_div (.clk_i(clk_i), .en_i(en), .mag_i(mag9_q[i]), .den_i(den9_q),
                    .q_o(dq[i]), .nz_o(dnz[i]));
  end

  // side band, dot sums, decision, offset and magnitude
  always_ff @(posedge clk_i) begin
    if (en) begin
      sh1_q  <= in_work_i.sh;
      sh2_q  <= sh1_q;
      sh3_q  <= sh2_q;
      sh4_q  <= sh3_q;
      sh5_q  <= sh4_q;
      den5_q <= pww[0] + pww[1] + pww[2];
      dcw5_q <= pdw[0] + pdw[1] + pdw[2];
      sn5_q  <= psw[0] + psw[1] + psw[2];
      tn5_q  <= ptw[0] + ptw[1] + ptw[2];
      hit6_q <= !sh5_q && (dcw5_q == '0) && (den5_q != '0)
             && !sn5_q[MULP_W-1] && !(sn5_q > den5_q)
             && !tn5_q[MULP_W-1] && !(tn5_q > den5_q);
      den6_q <= den5_q[DEN_W-1:0];
      hit7_q <= hit6_q;
      den7_q <= den6_q;
      hit8_q <= hit7_q;
      den8_q <= den7_q;
      hit9_q <= hit8_q;
      den9_q <= den8_q;
      for (int i = 0; i < 3; i++) begin
        as2_q[i]  <= as1_q[i];
        da2_q[i]  <= da1_q[i];
        dc2_q[i]  <= dc1_q[i];
        as3_q[i]  <= as2_q[i];
        da3_q[i]  <= da2_q[i];
        as4_q[i]  <= as3_q[i];
        da4_q[i]  <= da3_q[i];
        as5_q[i]  <= as4_q[i];
        da5_q[i]  <= da4_q[i];
        as6_q[i]  <= as5_q[i];
        as7_q[i]  <= as6_q[i];
        as8_q[i]  <= as7_q[i];
        as9_q[i]  <= as8_q[i];
        x8_q[i]   <= X_W'(pxl[i]) + (X_W'(pxh[i]) <<< SPLIT_W);
        neg9_q[i] <= x8_q[i][X_W-1];
        mag9_q[i] <= x8_q[i][X_W-1] ? MAG_W'(-x8_q[i]) : MAG_W'(x8_q[i]);
      end
      sb_q[0].hit <= hit9_q;
      sb_q[0].neg <= neg9_q;
      for (int i = 0; i < 3; i++) begin
        sb_q[0].as[i] <= as9_q[i];
      end
      for (int k = 1; k < Q_W; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // floor quotient to a result rounded toward zero
  always_comb begin
    logic signed [RES_W-1:0] base, qx, nzx, r0, r1;
    point_d = '0;
    for (int i = 0; i < 3; i++) begin
      base = RES_W'(sb_q[Q_W-1].as[i]);
      qx   = $signed({{(RES_W-Q_W){1'b0}}, dq[i]});
      nzx  = $signed({{(RES_W-1){1'b0}}, dnz[i]});
      r0   = sb_q[Q_W-1].neg[i] ? base - qx - nzx : base + qx;
      r1   = (r0[RES_W-1] && dnz[i]) ? r0 + RES_W'(1) : r0;
      if (sb_q[Q_W-1].hit) begin
        point_d[i*COORD_W +: COORD_W] = r1[COORD_W-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[LAT-2:0], in_valid_i};
      out_valid_q <= vld_q[LAT-1];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q   <= sb_q[Q_W-1].hit;
      out_point_q <= point_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_point_o = out_point_q;

endmodule

// ----- sv/segment_intersection_3d.sv -----
// Crossing point of two 3D segments with signed Q16.16 endpoints.
// Input channel s_axis: one item is a pair of segments, twelve coordinates
// packed into tdata. Output channel m_axis: one item per input item, with
// tuser set when the segments cross and tdata holding the point (all zero
// when they do not). Items come out in the order they went in.
// A front stage takes an item, forms the differences and the shared
// endpoint test, and pushes it into a four entry queue. The back end pops
// the queue and runs a 43 stage pipeline, output register included: cross
// products, exact dot products on split multipliers, the range tests, and
// a 33 stage restoring divider (one quotient bit per stage) for the point.
// Throughput is one item per cycle while m_axis is not stalled; the
// divider makes up most of the back end pipeline.
// When m_axis is stalled the back end holds, the queue and the front
// stage fill, and s_axis_tready drops only once all of them are full.
// Reset clears all valid bits and the queue; nothing else needs clearing.
module segment_intersection_3d import si3d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // a_start_x/y/z, a_end_x/y/z, b_start_x/y/z, b_end_x/y/z, 32 bits each
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // point_x, point_y, point_z, 32 bits each
  output logic [OUT_W-1:0] m_axis_tdata_o,
  // hit
  output logic             m_axis_tuser_o
);

  logic  f_valid, q_full, q_valid, q_pop;
  work_t f_work, q_work;

  si3d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .out_valid_o(f_valid),
    .out_ready_i(!q_full),
    .out_work_o (f_work)
  );

  si3d_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (f_valid),
    .push_data_i(f_work),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .data_o     (q_work)
  );

  si3d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_ready_o (q_pop),
    .in_work_i  (q_work),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_hit_o  (m_axis_tuser_o),
    .out_point_o(m_axis_tdata_o)
  );

endmodule
